FILE: hw/rtl/max_pool_with_argmax_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the max pooling block
// Concurrent check helpers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef MAX_POOL_WITH_ARGMAX_DEFINES_SVH
`define MAX_POOL_WITH_ARGMAX_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent
`define MPWA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: %m");
// Consequent must hold in the cycle after the antecedent
`define MPWA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: %m");
`else
`define MPWA_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define MPWA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/mpwa_pkg.sv
// ----------------------------------------------------------------------------
// mpwa_pkg
// Shared widths, register indexes and status structs of the pooling block.
// ----------------------------------------------------------------------------
package mpwa_pkg;

  localparam int PIX_W      = 16;
  localparam int POS_W      = 16;
  localparam int PLANE_W    = 4;
  localparam int OIDX_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam int IMG_DIM_W = 7;
  localparam int CHAN_W    = 5;
  localparam int WIN_W     = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_HEIGHT  = 3'd0,
    CFG_IMAGE_WIDTH   = 3'd1,
    CFG_CHANNEL_COUNT = 3'd2,
    CFG_WINDOW_HEIGHT = 3'd3,
    CFG_WINDOW_WIDTH  = 3'd4,
    CFG_STEP_SIZE     = 3'd5
  } cfg_idx_e;

  // Cursor status for the pixel now at the head of the stream
  typedef struct packed {
    logic fire;  // pixel completes a window
    logic last;  // pixel is the last of the sample
  } mpwa_evt_t;

  // Walk engine status towards the top level
  typedef struct packed {
    logic ready;      // free to take a pixel
    logic res_valid;  // finished window waiting for the output register
  } mpwa_wstat_t;

endpackage

FILE: hw/rtl/mpwa_cursor.sv
// ----------------------------------------------------------------------------
// mpwa_cursor
// Scan position, window trackers and flat index base of the incoming stream.
// ----------------------------------------------------------------------------
module mpwa_cursor import mpwa_pkg::*; #(
  parameter int MAX_HEIGHT   = 64,
  parameter int MAX_WIDTH    = 64,
  parameter int MAX_CHANNELS = 16,
  parameter int MAX_WINDOW   = 4,
  localparam int YW    = $clog2(MAX_HEIGHT + MAX_WINDOW),
  localparam int XW    = $clog2(MAX_WIDTH + MAX_WINDOW),
  localparam int CHW   = $clog2(MAX_CHANNELS + 1),
  localparam int KW    = $clog2(MAX_WINDOW + 1),
  localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             step_i,
  input  logic [YW-1:0]    height_i,
  input  logic [XW-1:0]    width_i,
  input  logic [CHW-1:0]   chans_i,
  input  logic [KW-1:0]    win_h_i,
  input  logic [KW-1:0]    win_w_i,
  input  logic [KW-1:0]    step_size_i,
  output mpwa_evt_t        evt_o,
  output logic [AW-1:0]    addr_o,
  output logic [CHW-1:0]   ch_o,
  output logic [YW-1:0]    row_idx_o,
  output logic [XW-1:0]    col_idx_o,
  output logic [YW-1:0]    row_beg_o,
  output logic [XW-1:0]    col_beg_o,
  output logic [KW-1:0]    dy_o,
  output logic [KW-1:0]    dx_o,
  output logic [POS_W-1:0] pbase_o
);

  logic [XW-1:0]    c_q, cbeg_q, cidx_q;
  logic [YW-1:0]    r_q, rbeg_q, ridx_q;
  logic [CHW-1:0]   ch_q;
  logic [AW-1:0]    addr_q;
  logic [POS_W-1:0] pbase_q;

  logic col_end, col_hit, row_end, row_hit, ch_end;

  always_comb begin
    col_end = (c_q == width_i - XW'(1));
    col_hit = (c_q == cbeg_q + XW'(win_w_i) - XW'(1));
    row_end = (r_q == height_i - YW'(1));
    row_hit = (r_q == rbeg_q + YW'(win_h_i) - YW'(1));
    ch_end  = (ch_q == chans_i - CHW'(1));
  end

  // The last column or row always closes the trailing, possibly clipped window
  assign evt_o.fire = (col_end || col_hit) && (row_end || row_hit);
  assign evt_o.last = col_end && row_end && ch_end;

  assign addr_o    = addr_q;
  assign ch_o      = ch_q;
  assign row_idx_o = ridx_q;
  assign col_idx_o = cidx_q;
  assign row_beg_o = rbeg_q;
  assign col_beg_o = cbeg_q;
  assign dy_o      = KW'(r_q - rbeg_q);
  assign dx_o      = KW'(c_q - cbeg_q);
  assign pbase_o   = pbase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q     <= '0;
      cbeg_q  <= '0;
      cidx_q  <= '0;
      r_q     <= '0;
      rbeg_q  <= '0;
      ridx_q  <= '0;
      ch_q    <= '0;
      addr_q  <= '0;
      pbase_q <= '0;
    end else if (clear_i) begin
      c_q     <= '0;
      cbeg_q  <= '0;
      cidx_q  <= '0;
      r_q     <= '0;
      rbeg_q  <= '0;
      ridx_q  <= '0;
      ch_q    <= '0;
      addr_q  <= '0;
      pbase_q <= '0;
    end else if (step_i) begin
      if (col_end) begin
        c_q    <= '0;
        cbeg_q <= '0;
        cidx_q <= '0;
        if (row_end) begin
          r_q    <= '0;
          rbeg_q <= '0;
          ridx_q <= '0;
          addr_q <= '0;
          if (ch_end) begin
            ch_q    <= '0;
            pbase_q <= '0;
          end else begin
            ch_q    <= ch_q + CHW'(1);
            pbase_q <= pbase_q + POS_W'(addr_q) + POS_W'(1);
          end
        end else begin
          r_q    <= r_q + YW'(1);
          addr_q <= addr_q + AW'(1);
          if (row_hit) begin
            rbeg_q <= rbeg_q + YW'(step_size_i);
            ridx_q <= ridx_q + YW'(1);
          end
        end
      end else begin
        c_q    <= c_q + XW'(1);
        addr_q <= addr_q + AW'(1);
        if (col_hit) begin
          cbeg_q <= cbeg_q + XW'(step_size_i);
          cidx_q <= cidx_q + XW'(1);
        end
      end
    end
  end

endmodule

FILE: hw/rtl/mpwa_walk.sv
// ----------------------------------------------------------------------------
// mpwa_walk
// Plane store and the sequencer that scans a finished window with one comparator.
// ----------------------------------------------------------------------------
module mpwa_walk import mpwa_pkg::*; #(
  parameter int MAX_HEIGHT   = 64,
  parameter int MAX_WIDTH    = 64,
  parameter int MAX_CHANNELS = 16,
  parameter int MAX_WINDOW   = 4,
  localparam int YW    = $clog2(MAX_HEIGHT + MAX_WINDOW),
  localparam int XW    = $clog2(MAX_WIDTH + MAX_WINDOW),
  localparam int CHW   = $clog2(MAX_CHANNELS + 1),
  localparam int KW    = $clog2(MAX_WINDOW + 1),
  localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic signed [PIX_W-1:0] pixel_i,
  input  mpwa_evt_t               evt_i,
  input  logic [AW-1:0]           addr_i,
  input  logic [CHW-1:0]          ch_i,
  input  logic [YW-1:0]           row_idx_i,
  input  logic [XW-1:0]           col_idx_i,
  input  logic [YW-1:0]           row_beg_i,
  input  logic [XW-1:0]           col_beg_i,
  input  logic [KW-1:0]           dy_i,
  input  logic [KW-1:0]           dx_i,
  input  logic [POS_W-1:0]        pbase_i,
  input  logic [XW-1:0]           width_i,
  input  logic                    take_i,
  output mpwa_wstat_t             stat_o,
  output logic signed [PIX_W-1:0] max_value_o,
  output logic [POS_W-1:0]        max_pos_o,
  output logic [PLANE_W-1:0]      plane_o,
  output logic [OIDX_W-1:0]       row_o,
  output logic [OIDX_W-1:0]       col_o,
  output logic                    last_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_EMIT  = 5'b10000
  } walk_state_e;

  walk_state_e state_q, state_d;

  logic [PIX_W-1:0] mem [DEPTH];

  // window geometry and result tags, held for the whole scan
  logic [YW-1:0]        r0_q;
  logic [XW-1:0]        c0_q;
  logic [KW-1:0]        dy_q, dx_q, y_q, x_q;
  logic [POS_W-1:0]     pbase_q;
  logic [PLANE_W-1:0]   plane_q;
  logic [OIDX_W-1:0]    orow_q, ocol_q;
  logic                 last_q;

  logic [AW-1:0]        row_addr_q;
  logic [AW-1:0]        rd_addr, rd_addr_q;
  logic                 rd_vld_q;
  logic [PIX_W-1:0]     rdata_q;

  logic signed [PIX_W-1:0] best_q;
  logic [POS_W-1:0]        bpos_q;
  logic                    have_q;

  logic [YW+XW-1:0] row_off;
  logic             wr_en, rd_en, scan_x_end, scan_y_end;

  assign wr_en      = accept_i && (state_q == ST_IDLE);
  assign rd_en      = (state_q == ST_SCAN);
  assign rd_addr    = row_addr_q + AW'(x_q);
  assign scan_x_end = (x_q == dx_q);
  assign scan_y_end = (y_q == dy_q);
  assign row_off    = r0_q * width_i;

  // store: one write port for arriving pixels, one registered read port for the scan
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[addr_i] <= pixel_i;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept_i && evt_i.fire) state_d = ST_SETUP;
      end
      ST_SETUP: state_d = ST_SCAN;
      ST_SCAN: begin
        if (scan_x_end && scan_y_end) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_EMIT;
      ST_EMIT: begin
        if (take_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_vld_q <= 1'b0;
      have_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      if (state_q == ST_SETUP) begin
        have_q <= 1'b0;
      end else if (rd_vld_q) begin
        have_q <= 1'b1;
      end
    end
  end

  // latch the window on the completing pixel
  always_ff @(posedge clk_i) begin
    if (wr_en && evt_i.fire) begin
      r0_q    <= row_beg_i;
      c0_q    <= col_beg_i;
      dy_q    <= dy_i;
      dx_q    <= dx_i;
      pbase_q <= pbase_i;
      plane_q <= PLANE_W'(ch_i);
      orow_q  <= OIDX_W'(row_idx_i);
      ocol_q  <= OIDX_W'(col_idx_i);
      last_q  <= evt_i.last;
    end
  end

  // scan address generator: row by row, left to right
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SETUP) begin
      row_addr_q <= AW'(row_off) + AW'(c0_q);
      x_q        <= '0;
      y_q        <= '0;
    end else if (state_q == ST_SCAN) begin
      if (scan_x_end) begin
        x_q        <= '0;
        y_q        <= y_q + KW'(1);
        row_addr_q <= row_addr_q + AW'(width_i);
      end else begin
        x_q <= x_q + KW'(1);
      end
    end
    rd_addr_q <= rd_addr;
  end

  // shared comparator; ties go to the later pixel
  always_ff @(posedge clk_i) begin
    if (rd_vld_q && (!have_q || ($signed(rdata_q) >= best_q))) begin
      best_q <= $signed(rdata_q);
      bpos_q <= pbase_q + POS_W'(rd_addr_q);
    end
  end

  assign stat_o.ready     = (state_q == ST_IDLE);
  assign stat_o.res_valid = (state_q == ST_EMIT);
  assign max_value_o      = best_q;
  assign max_pos_o        = bpos_q;
  assign plane_o          = plane_q;
  assign row_o            = orow_q;
  assign col_o            = ocol_q;
  assign last_o           = last_q;

endmodule

FILE: hw/rtl/max_pool_with_argmax.sv
// ----------------------------------------------------------------------------
// max_pool_with_argmax
// Streaming 2-D max pooling with argmax over a stored channel plane.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one signed Q8.8 pixel per request on pixel_value_i, in
//   channel, row, column order. A request is taken when in_valid_i is high and
//   in_stall_o is low.
//   Output channel: one request per finished window, carrying the maximum, the
//   flat index of the winning pixel, the channel, the output row and column
//   and a last-window flag. It is taken when out_valid_o is high and
//   out_stall_i is low.
//   A pixel that closes no window does not stall the input. A pixel that
//   closes a window of n stored pixels (n up to MAX_WINDOW squared) keeps
//   in_stall_o high through window setup, one store read per pixel through
//   a single registered read port, a drain step for the last compare and a
//   hand-over step in which the output register takes the result. The read
//   port and the one comparator scan the window one stored pixel at a time.
//   A stalled output register holds; the next pixel is still taken and its
//   window scanned, and the engine waits for the register only at hand-over.
//   Reset loads the default geometry (28 x 28, one channel, 2 x 2, step 2)
//   and begins a new sample. A write to any known register also begins a new
//   sample; a write to a spare index changes nothing. Write configuration
//   only while idle.
// ----------------------------------------------------------------------------
`include "max_pool_with_argmax_defines.svh"

module max_pool_with_argmax import mpwa_pkg::*; #(
  parameter int MAX_HEIGHT   = 64,
  parameter int MAX_WIDTH    = 64,
  parameter int MAX_CHANNELS = 16,
  parameter int MAX_WINDOW   = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // pixel requests
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [PIX_W-1:0] pixel_value_i,
  // window result requests
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [PIX_W-1:0] max_value_o,
  output logic [POS_W-1:0]        max_position_o,
  output logic [PLANE_W-1:0]      plane_index_o,
  output logic [OIDX_W-1:0]       out_row_o,
  output logic [OIDX_W-1:0]       out_col_o,
  output logic                    sample_done_o,
  // configuration writes
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int YW    = $clog2(MAX_HEIGHT + MAX_WINDOW);
  localparam int XW    = $clog2(MAX_WIDTH + MAX_WINDOW);
  localparam int CHW   = $clog2(MAX_CHANNELS + 1);
  localparam int KW    = $clog2(MAX_WINDOW + 1);
  localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration registers, raw as written
  logic [IMG_DIM_W-1:0] img_h_q, img_w_q;
  logic [CHAN_W-1:0]    chans_q;
  logic [WIN_W-1:0]     win_h_q, win_w_q, step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_h_q <= IMG_DIM_W'(28);
      img_w_q <= IMG_DIM_W'(28);
      chans_q <= CHAN_W'(1);
      win_h_q <= WIN_W'(2);
      win_w_q <= WIN_W'(2);
      step_q  <= WIN_W'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_HEIGHT:  img_h_q <= cfg_data_i[IMG_DIM_W-1:0];
        CFG_IMAGE_WIDTH:   img_w_q <= cfg_data_i[IMG_DIM_W-1:0];
        CFG_CHANNEL_COUNT: chans_q <= cfg_data_i[CHAN_W-1:0];
        CFG_WINDOW_HEIGHT: win_h_q <= cfg_data_i[WIN_W-1:0];
        CFG_WINDOW_WIDTH:  win_w_q <= cfg_data_i[WIN_W-1:0];
        CFG_STEP_SIZE:     step_q  <= cfg_data_i[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Restart the sample only on a write to a known register
  logic cfg_restart;

  assign cfg_restart = cfg_we_i && (cfg_idx_i <= CFG_STEP_SIZE);

  // Clamp the geometry into range: sizes to their limits, windows to the
  // image, the step to the smaller window side.
  logic [YW-1:0]  h_eff;
  logic [XW-1:0]  w_eff;
  logic [CHW-1:0] c_eff;
  logic [KW-1:0]  ph_lim, pw_lim, ph_eff, pw_eff, s_lim, s_eff;

  always_comb begin
    if (img_h_q == '0)            h_eff = YW'(1);
    else if (img_h_q > MAX_HEIGHT) h_eff = YW'(MAX_HEIGHT);
    else                           h_eff = YW'(img_h_q);

    if (img_w_q == '0)            w_eff = XW'(1);
    else if (img_w_q > MAX_WIDTH) w_eff = XW'(MAX_WIDTH);
    else                          w_eff = XW'(img_w_q);

    if (chans_q == '0)               c_eff = CHW'(1);
    else if (chans_q > MAX_CHANNELS) c_eff = CHW'(MAX_CHANNELS);
    else                             c_eff = CHW'(chans_q);

    if (win_h_q == '0)             ph_lim = KW'(1);
    else if (win_h_q > MAX_WINDOW) ph_lim = KW'(MAX_WINDOW);
    else                           ph_lim = KW'(win_h_q);
    ph_eff = (ph_lim > h_eff) ? KW'(h_eff) : ph_lim;

    if (win_w_q == '0)             pw_lim = KW'(1);
    else if (win_w_q > MAX_WINDOW) pw_lim = KW'(MAX_WINDOW);
    else                           pw_lim = KW'(win_w_q);
    pw_eff = (pw_lim > w_eff) ? KW'(w_eff) : pw_lim;

    s_lim = (ph_eff < pw_eff) ? ph_eff : pw_eff;
    if (step_q == '0)         s_eff = KW'(1);
    else if (step_q > s_lim)  s_eff = s_lim;
    else                      s_eff = KW'(step_q);
  end

  // Scan cursor
  mpwa_evt_t        cur_evt;
  logic [AW-1:0]    cur_addr;
  logic [CHW-1:0]   cur_ch;
  logic [YW-1:0]    cur_ridx, cur_rbeg;
  logic [XW-1:0]    cur_cidx, cur_cbeg;
  logic [KW-1:0]    cur_dy, cur_dx;
  logic [POS_W-1:0] cur_pbase;
  logic             in_take;

  mpwa_wstat_t wstat;

  assign in_stall_o = !wstat.ready;
  assign in_take    = in_valid_i && wstat.ready;

  mpwa_cursor #(
    .MAX_HEIGHT  (MAX_HEIGHT),
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_cursor (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (cfg_restart),
    .step_i     (in_take),
    .height_i   (h_eff),
    .width_i    (w_eff),
    .chans_i    (c_eff),
    .win_h_i    (ph_eff),
    .win_w_i    (pw_eff),
    .step_size_i(s_eff),
    .evt_o      (cur_evt),
    .addr_o     (cur_addr),
    .ch_o       (cur_ch),
    .row_idx_o  (cur_ridx),
    .col_idx_o  (cur_cidx),
    .row_beg_o  (cur_rbeg),
    .col_beg_o  (cur_cbeg),
    .dy_o       (cur_dy),
    .dx_o       (cur_dx),
    .pbase_o    (cur_pbase)
  );

  // Window scan engine and plane store
  logic signed [PIX_W-1:0] res_value;
  logic [POS_W-1:0]        res_pos;
  logic [PLANE_W-1:0]      res_plane;
  logic [OIDX_W-1:0]       res_row, res_col;
  logic                    res_last;
  logic                    out_load;

  mpwa_walk #(
    .MAX_HEIGHT  (MAX_HEIGHT),
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_valid_i),
    .pixel_i    (pixel_value_i),
    .evt_i      (cur_evt),
    .addr_i     (cur_addr),
    .ch_i       (cur_ch),
    .row_idx_i  (cur_ridx),
    .col_idx_i  (cur_cidx),
    .row_beg_i  (cur_rbeg),
    .col_beg_i  (cur_cbeg),
    .dy_i       (cur_dy),
    .dx_i       (cur_dx),
    .pbase_i    (cur_pbase),
    .width_i    (w_eff),
    .take_i     (out_load),
    .stat_o     (wstat),
    .max_value_o(res_value),
    .max_pos_o  (res_pos),
    .plane_o    (res_plane),
    .row_o      (res_row),
    .col_o      (res_col),
    .last_o     (res_last)
  );

  // Output register: load a finished window when empty or being drained this cycle, hold otherwise
  logic out_valid_q;

  assign out_load = wstat.res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      max_value_o    <= res_value;
      max_position_o <= res_pos;
      plane_index_o  <= res_plane;
      out_row_o      <= res_row;
      out_col_o      <= res_col;
      sample_done_o  <= res_last;
    end
  end

  assign out_valid_o = out_valid_q;

  // A pixel that closes a window must stall the input while it is scanned
  `MPWA_ASSERT_NEXT(a_fire_stalls, clk_i, rst_ni, in_take && cur_evt.fire && !cfg_we_i, in_stall_o)
  // A finished window handed over always shows on the output next cycle
  `MPWA_ASSERT_NEXT(a_load_shows, clk_i, rst_ni, out_load, out_valid_o)
  // A known register write restarts the sample at the first window
  `MPWA_ASSERT_NEXT(a_cfg_restart, clk_i, rst_ni, cfg_restart, cur_ch == '0 && cur_ridx == '0 && cur_cidx == '0)
  // No result is offered while the engine is free to take pixels
  `MPWA_ASSERT_SAME(a_idle_no_result, clk_i, rst_ni, wstat.ready, !wstat.res_valid)

endmodule
